// File: design/pesm_pkg.sv
// Shared types and constants of the pointer event scroll mapper.
package pesm_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_SWAP_AXES   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INVERT_X    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INVERT_Y    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_MUL   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_DIV   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SCROLL_STEP = 3'd5;

  // Register reset values
  localparam logic [15:0] SCALE_MUL_RST   = 16'd1;
  localparam logic [15:0] SCALE_DIV_RST   = 16'd1;
  localparam logic [7:0]  SCROLL_STEP_RST = 8'd12;

  // Event types and codes
  localparam logic [1:0] FUNC_REL = 2'd0;
  localparam logic [1:0] FUNC_KEY = 2'd1;
  localparam logic [2:0] CODE_X       = 3'd0;
  localparam logic [2:0] CODE_Y       = 3'd1;
  localparam logic [2:0] CODE_WHEEL   = 3'd2;
  localparam logic [2:0] CODE_HWHEEL  = 3'd3;
  localparam logic [2:0] CODE_BTN_MAX = 3'd4;

  // Divider iteration counts, minus one
  localparam logic [4:0] DIV_CNT_SCALE = 5'd31;
  localparam logic [4:0] DIV_CNT_TICK  = 5'd15;

  typedef enum logic [2:0] {
    ACT_MOVE    = 3'd0,
    ACT_SCROLL  = 3'd1,
    ACT_PRESS   = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_SEND    = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DLOAD,
    S_DSCALE,
    S_SFIX,
    S_ROUTE,
    S_TLOAD,
    S_TDIV,
    S_TFIX,
    S_TREM,
    S_OUTP,
    S_OUTS
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic div_load_scale;
    logic div_load_tick;
    logic div_step;
    logic scale_fix;
    logic acc;
    logic tick_fix;
    logic rem_upd;
    logic out_load;
    logic out_sel_sync;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg;
    logic need_acc;
    logic div_last;
    logic out_free;
    logic prim_v;
    logic sync;
  } ctrl_sts_t;

endpackage

// File: design/pesm_ctrl.sv
// Sequencing state machine of the pointer event scroll mapper.
module pesm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output pesm_pkg::ctrl_cmd_t   cmd,
  input  pesm_pkg::ctrl_sts_t   sts
);

  pesm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pesm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pesm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pesm_pkg::S_MUL;
      end
      pesm_pkg::S_MUL: begin
        state_nxt = sts.cfg ? pesm_pkg::S_DLOAD : pesm_pkg::S_ROUTE;
      end
      pesm_pkg::S_DLOAD:  state_nxt = pesm_pkg::S_DSCALE;
      pesm_pkg::S_DSCALE: begin
        if (sts.div_last) state_nxt = pesm_pkg::S_SFIX;
      end
      pesm_pkg::S_SFIX:   state_nxt = pesm_pkg::S_ROUTE;
      pesm_pkg::S_ROUTE: begin
        state_nxt = sts.need_acc ? pesm_pkg::S_TLOAD : pesm_pkg::S_OUTP;
      end
      pesm_pkg::S_TLOAD:  state_nxt = pesm_pkg::S_TDIV;
      pesm_pkg::S_TDIV: begin
        if (sts.div_last) state_nxt = pesm_pkg::S_TFIX;
      end
      pesm_pkg::S_TFIX:   state_nxt = pesm_pkg::S_TREM;
      pesm_pkg::S_TREM:   state_nxt = pesm_pkg::S_OUTP;
      pesm_pkg::S_OUTP: begin
        if (!sts.prim_v) begin
          state_nxt = sts.sync ? pesm_pkg::S_OUTS : pesm_pkg::S_IDLE;
        end else if (sts.out_free) begin
          state_nxt = sts.sync ? pesm_pkg::S_OUTS : pesm_pkg::S_IDLE;
        end
      end
      pesm_pkg::S_OUTS: begin
        if (sts.out_free) state_nxt = pesm_pkg::S_IDLE;
      end
      default: state_nxt = pesm_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      pesm_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      pesm_pkg::S_MUL:    cmd.mul            = sts.cfg;
      pesm_pkg::S_DLOAD:  cmd.div_load_scale = 1'b1;
      pesm_pkg::S_DSCALE: cmd.div_step       = 1'b1;
      pesm_pkg::S_SFIX:   cmd.scale_fix      = 1'b1;
      pesm_pkg::S_ROUTE:  cmd.acc            = sts.need_acc;
      pesm_pkg::S_TLOAD:  cmd.div_load_tick  = 1'b1;
      pesm_pkg::S_TDIV:   cmd.div_step       = 1'b1;
      pesm_pkg::S_TFIX:   cmd.tick_fix       = 1'b1;
      pesm_pkg::S_TREM:   cmd.rem_upd        = 1'b1;
      pesm_pkg::S_OUTP:   cmd.out_load       = sts.prim_v & sts.out_free;
      pesm_pkg::S_OUTS: begin
        cmd.out_load     = sts.out_free;
        cmd.out_sel_sync = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/pesm_dp.sv
// Datapath: config registers, scaler, shared divider, scroll remainders, result register.
module pesm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pesm_pkg::ctrl_cmd_t           cmd,
  output pesm_pkg::ctrl_sts_t           sts,
  input  logic [1:0]                    in_func,
  input  logic [2:0]                    in_event_code,
  input  logic signed [15:0]            in_event_value,
  input  logic                          in_sync_flag,
  input  logic                          in_config_applies,
  input  logic                          in_scroll_mode,
  input  logic                          cfg_valid,
  input  logic [pesm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [15:0]                   cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_action,
  output logic signed [15:0]            out_delta_x,
  output logic signed [15:0]            out_delta_y,
  output logic [2:0]                    out_button_index,
  output logic                          out_last_flag
);

  // Configuration
  logic        swap_r, inv_x_r, inv_y_r;
  logic [15:0] mul_r, div_r;
  logic [7:0]  step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r  <= 1'b0;
      inv_x_r <= 1'b0;
      inv_y_r <= 1'b0;
      mul_r   <= pesm_pkg::SCALE_MUL_RST;
      div_r   <= pesm_pkg::SCALE_DIV_RST;
      step_r  <= pesm_pkg::SCROLL_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pesm_pkg::CFG_SWAP_AXES:   swap_r  <= cfg_data[0];
        pesm_pkg::CFG_INVERT_X:    inv_x_r <= cfg_data[0];
        pesm_pkg::CFG_INVERT_Y:    inv_y_r <= cfg_data[0];
        pesm_pkg::CFG_SCALE_MUL:   mul_r   <= cfg_data;
        pesm_pkg::CFG_SCALE_DIV:   div_r   <= cfg_data;
        pesm_pkg::CFG_SCROLL_STEP: step_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [15:0] div_eff;
  logic [7:0]  step_eff;
  assign div_eff  = (div_r == 16'd0) ? 16'd1 : div_r;
  assign step_eff = (step_r == 8'd0) ? 8'd1 : step_r;

  // Captured event
  logic [1:0]         func_r;
  logic [2:0]         code_r;
  logic signed [15:0] value_r;
  logic               sync_r, cfg_r, scroll_r;
  logic               swap_now;

  assign swap_now = in_config_applies && swap_r && (in_func == pesm_pkg::FUNC_REL) &&
                    ((in_event_code == pesm_pkg::CODE_X) || (in_event_code == pesm_pkg::CODE_Y));

  // Scaler
  logic               inv_now;
  logic signed [16:0] vext, vinv;
  logic signed [33:0] prod_full;
  logic signed [32:0] prod_r;
  logic [32:0]        prod_mag;

  assign inv_now = (func_r == pesm_pkg::FUNC_REL) &&
                   ((inv_x_r && (code_r == pesm_pkg::CODE_X)) ||
                    (inv_y_r && (code_r == pesm_pkg::CODE_Y)));
  assign vext      = {value_r[15], value_r};
  assign vinv      = inv_now ? -vext : vext;
  assign prod_full = vinv * $signed({1'b0, mul_r});
  assign prod_mag  = prod_r[32] ? 33'(-prod_r) : 33'(prod_r);

  // Shared restoring divider, one quotient bit per cycle
  logic [31:0] q_r;
  logic [15:0] rem_r, dvs_r;
  logic [4:0]  cnt_r;
  logic        neg_r;
  logic [17:0] trial;
  logic        borrow;

  assign trial  = {1'b0, rem_r, q_r[31]} - {2'b00, dvs_r};
  assign borrow = trial[17];

  // Scroll accumulation
  logic signed [15:0] rem_x_r, rem_y_r, acc_r;
  logic signed [7:0]  tick_r;
  logic               tick_nz_r;
  logic [16:0]        acc_mag;
  logic signed [16:0] tprod;
  logic signed [15:0] rem_new;

  assign acc_mag = acc_r[15] ? 17'(-{acc_r[15], acc_r}) : {acc_r[15], acc_r};
  assign tprod   = tick_r * $signed({1'b0, step_eff});
  assign rem_new = tick_nz_r ? (acc_r - tprod[15:0]) : acc_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r   <= in_func;
      code_r   <= swap_now ? (in_event_code ^ 3'd1) : in_event_code;
      value_r  <= in_event_value;
      sync_r   <= in_sync_flag;
      cfg_r    <= in_config_applies;
      scroll_r <= in_scroll_mode;
    end else if (cmd.scale_fix) begin
      value_r  <= neg_r ? 16'(-q_r[15:0]) : q_r[15:0];
    end
    if (cmd.mul) prod_r <= prod_full[32:0];
    if (cmd.acc) begin
      acc_r <= ((code_r == pesm_pkg::CODE_X) ? rem_x_r : rem_y_r) + value_r;
    end
    if (cmd.tick_fix) begin
      tick_r    <= neg_r ? 8'(-q_r[7:0]) : q_r[7:0];
      tick_nz_r <= |q_r[15:0];
    end
    if (cmd.div_load_scale) begin
      q_r   <= prod_mag[31:0];
      rem_r <= 16'd0;
      dvs_r <= div_eff;
      neg_r <= prod_r[32];
    end else if (cmd.div_load_tick) begin
      q_r   <= {acc_mag[15:0], 16'd0};
      rem_r <= 16'd0;
      dvs_r <= {8'd0, step_eff};
      neg_r <= acc_r[15];
    end else if (cmd.div_step) begin
      q_r   <= {q_r[30:0], ~borrow};
      rem_r <= borrow ? {rem_r[14:0], q_r[31]} : trial[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 5'd0;
    end else if (cmd.div_load_scale) begin
      cnt_r <= pesm_pkg::DIV_CNT_SCALE;
    end else if (cmd.div_load_tick) begin
      cnt_r <= pesm_pkg::DIV_CNT_TICK;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (cmd.rem_upd) begin
      if (code_r == pesm_pkg::CODE_X) rem_x_r <= rem_new;
      else                            rem_y_r <= rem_new;
    end
  end

  // Primary result of the event
  logic               prim_v;
  pesm_pkg::action_t  prim_act;
  logic signed [15:0] prim_dx, prim_dy;
  logic [2:0]         prim_btn;
  logic signed [7:0]  tick_neg;

  assign tick_neg = -tick_r;

  always_comb begin
    prim_v   = 1'b0;
    prim_act = pesm_pkg::ACT_MOVE;
    prim_dx  = '0;
    prim_dy  = '0;
    prim_btn = 3'd0;
    if (func_r == pesm_pkg::FUNC_REL) begin
      priority case (code_r)
        pesm_pkg::CODE_X: begin
          if (!scroll_r) begin
            prim_v  = 1'b1;
            prim_dx = value_r;
          end else begin
            prim_v   = tick_nz_r;
            prim_act = pesm_pkg::ACT_SCROLL;
            prim_dx  = 16'(tick_r);
          end
        end
        pesm_pkg::CODE_Y: begin
          if (!scroll_r) begin
            prim_v  = 1'b1;
            prim_dy = value_r;
          end else begin
            prim_v   = tick_nz_r;
            prim_act = pesm_pkg::ACT_SCROLL;
            prim_dy  = 16'(tick_neg);
          end
        end
        pesm_pkg::CODE_WHEEL: begin
          prim_v   = 1'b1;
          prim_act = pesm_pkg::ACT_SCROLL;
          prim_dy  = value_r;
        end
        pesm_pkg::CODE_HWHEEL: begin
          prim_v   = 1'b1;
          prim_act = pesm_pkg::ACT_SCROLL;
          prim_dx  = value_r;
        end
        default: prim_v = 1'b0;
      endcase
    end else if (func_r == pesm_pkg::FUNC_KEY) begin
      if (code_r <= pesm_pkg::CODE_BTN_MAX) begin
        prim_v   = 1'b1;
        prim_btn = code_r;
        prim_act = (!value_r[15] && (value_r != 16'sd0)) ? pesm_pkg::ACT_PRESS
                                                         : pesm_pkg::ACT_RELEASE;
      end
    end
  end

  // Result register
  logic               out_valid_r;
  pesm_pkg::action_t  out_action_r;
  logic signed [15:0] out_dx_r, out_dy_r;
  logic [2:0]         out_btn_r;
  logic               out_last_r;
  logic               out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_sel_sync) begin
        out_action_r <= pesm_pkg::ACT_SEND;
        out_dx_r     <= '0;
        out_dy_r     <= '0;
        out_btn_r    <= 3'd0;
        out_last_r   <= 1'b1;
      end else begin
        out_action_r <= prim_act;
        out_dx_r     <= prim_dx;
        out_dy_r     <= prim_dy;
        out_btn_r    <= prim_btn;
        out_last_r   <= !sync_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_delta_x      = out_dx_r;
  assign out_delta_y      = out_dy_r;
  assign out_button_index = out_btn_r;
  assign out_last_flag    = out_last_r;

  assign sts.cfg      = cfg_r;
  assign sts.need_acc = scroll_r && (func_r == pesm_pkg::FUNC_REL) &&
                        ((code_r == pesm_pkg::CODE_X) || (code_r == pesm_pkg::CODE_Y));
  assign sts.div_last = (cnt_r == 5'd0);
  assign sts.out_free = out_free;
  assign sts.prim_v   = prim_v;
  assign sts.sync     = sync_r;

endmodule

// File: design/pointer_event_scroll_mapper.sv
// Top level of the pointer event scroll mapper: controller, datapath and checks.
//
// Takes one pointer event item at a time and gives zero, one or two result items
// (an action, then a send-and-clear when the sync flag is set; last_flag marks the
// final one). Without scaling or scroll accumulation an event passes through the
// multiply slot, route, result load and idle from its acceptance to the next
// acceptance, plus a send-and-clear state when the sync flag is set. Scaling adds a
// divider load, a restoring divider that produces one quotient bit per cycle over 32
// bits, then the sign fix; the 17x16 multiply uses the multiply slot. A scroll-mode
// X or Y delta adds a divider load, the same divider over 16 bits for the tick count,
// the tick sign fix, then the remainder update. Any output stall adds to this. The
// divider is shared, so its bit-per-cycle loop sets the rate. A finished result sits
// in an output register; while it waits the controller holds off the next event only
// if a further result of the same event still has to go out. Config writes are taken
// every cycle (cfg_ready is tied high) and must only happen while the block is idle.
// Scroll remainders reset to zero; divisor and scroll step of zero act as one.
module pointer_event_scroll_mapper (
  input  logic                          clk,
  input  logic                          rst_n,
  // event items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [2:0]                    in_event_code,
  input  logic signed [15:0]            in_event_value,
  input  logic                          in_sync_flag,
  input  logic                          in_config_applies,
  input  logic                          in_scroll_mode,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_action,
  output logic signed [15:0]            out_delta_x,
  output logic signed [15:0]            out_delta_y,
  output logic [2:0]                    out_button_index,
  output logic                          out_last_flag,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pesm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [15:0]                   cfg_data
);

  pesm_pkg::ctrl_cmd_t cmd;
  pesm_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  pesm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  pesm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_event_code     (in_event_code),
    .in_event_value    (in_event_value),
    .in_sync_flag      (in_sync_flag),
    .in_config_applies (in_config_applies),
    .in_scroll_mode    (in_scroll_mode),
    .cfg_valid         (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_delta_x       (out_delta_x),
    .out_delta_y       (out_delta_y),
    .out_button_index  (out_button_index),
    .out_last_flag     (out_last_flag)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the input side closed while it is processed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting an item");

  // Send-and-clear is always the final result of its item
  a_send_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_action == pesm_pkg::ACT_SEND)) |-> out_last_flag)
    else $error("send-and-clear result not marked last");

  // Button results carry no motion
  a_button_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_action == pesm_pkg::ACT_PRESS) ||
                   (out_action == pesm_pkg::ACT_RELEASE)))
      |-> ((out_delta_x == 16'sd0) && (out_delta_y == 16'sd0)))
    else $error("button result with nonzero delta");

  // Move and scroll results carry no button number
  a_motion_no_button: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_action == pesm_pkg::ACT_MOVE) ||
                   (out_action == pesm_pkg::ACT_SCROLL)))
      |-> (out_button_index == 3'd0))
    else $error("motion result with button index");
`endif

endmodule
